// ===== rtl/core/sle_pkg.sv =====
// Shared types and constants of the sorted list engine.
package sle_pkg;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_INSERT     = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_REMOVE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   localparam int COUNT_BITS = 5;

   typedef struct packed {
      op_type op;
      logic   commit;
   } cell_cmd_type;

endpackage

// ===== rtl/core/sle_cell.sv =====
// One list position: holds an entry, matches it against the operand and shifts.
module sle_cell
   import sle_pkg::*;
#(
   parameter int VALUE_BITS = 32,
   parameter bit IS_HEAD    = 1'b0
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [VALUE_BITS-1:0] value,
   input  logic                  in_list,
   input  logic [VALUE_BITS-1:0] left_entry,
   input  logic [VALUE_BITS-1:0] right_entry,
   input  logic                  hit_in,
   output logic [VALUE_BITS-1:0] entry,
   output logic                  hit_out
);

   logic [VALUE_BITS-1:0] entry_ff;
   logic [VALUE_BITS-1:0] entry_in;
   logic                  match;
   logic                  entry_lt;
   logic                  value_lt;

   assign entry_lt = $signed(entry_ff) < $signed(value);
   assign value_lt = $signed(value) < $signed(entry_ff);

   always_comb begin
      unique case (cmd.op)
         OP_PUSH_FRONT: match = 1'b1;
         OP_INSERT: begin
            if (IS_HEAD) begin
               match = !in_list || value_lt;
            end else begin
               match = !in_list || !entry_lt;
            end
         end
         OP_POP_FRONT:  match = 1'b1;
         OP_REMOVE:     match = in_list && (entry_ff == value);
         default:       match = 1'b0;
      endcase
   end

   assign hit_out = hit_in | match;

   always_comb begin
      unique case (cmd.op)
         OP_PUSH_FRONT, OP_INSERT: begin
            if (hit_in) begin
               entry_in = left_entry;
            end else if (match) begin
               entry_in = value;
            end else begin
               entry_in = entry_ff;
            end
         end
         OP_POP_FRONT: entry_in = right_entry;
         OP_REMOVE:    entry_in = (hit_in | match) ? right_entry : entry_ff;
         default:      entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/core/sorted_list_engine.sv =====
// Top level of the sorted list engine: cell chain, occupancy and result register.
//
// The engine completes each list operation on the edge that takes its request
// beat: every cell compares its entry with the operand at once and a one-bit
// match signal ripples down the row of cells, which fixes the insert or delete
// position and sets the clock period. The result beat is held in an output
// register; a new request is taken whenever that register is empty or is
// drained in the same cycle, so the rate is one operation per cycle while rsp_tready holds.
// Entry count and head value in the result show the list state after the
// operation. No clearing pass is needed after reset.
module sorted_list_engine
   import sle_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // Fields from bit 0: value.
   input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0: operation.
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // Fields from bit 0: entry_count, head_value.
   output logic [((COUNT_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Fields from bit 0: status.
   output logic [1:0]           rsp_tuser
);

   localparam int RSP_BITS = ((COUNT_BITS + VALUE_BITS + 7) / 8) * 8;
   localparam int OCC_BITS = $clog2(DEPTH + 1);
   localparam int PAD_BITS = RSP_BITS - COUNT_BITS - VALUE_BITS;

   logic [OCC_BITS-1:0]   occ_ff;
   logic [OCC_BITS-1:0]   occ_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            status_ff;
   status_type            status_in;
   logic                  accept;
   op_type                op;
   logic [VALUE_BITS-1:0] value;
   cell_cmd_type          cmd;
   logic [VALUE_BITS-1:0] entries [DEPTH];
   logic [DEPTH:0]        hit;
   logic                  full;
   logic                  empty;
   logic [COUNT_BITS-1:0] count_out;
   logic [VALUE_BITS-1:0] head_out;

   assign op         = op_type'(req_tuser);
   assign value      = req_tdata[VALUE_BITS-1:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (occ_ff == OCC_BITS'(DEPTH));
   assign empty      = (occ_ff == '0);

   assign hit[0] = 1'b0;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [VALUE_BITS-1:0] left_entry;
      logic [VALUE_BITS-1:0] right_entry;
      logic                  in_list;

      assign left_entry  = (k == 0) ? entries[k] : entries[(k == 0) ? 0 : k - 1];
      assign right_entry = (k == DEPTH - 1) ? entries[k]
                                            : entries[(k == DEPTH - 1) ? k : k + 1];
      assign in_list     = OCC_BITS'(k) < occ_ff;

      sle_cell #(
         .VALUE_BITS (VALUE_BITS),
         .IS_HEAD    (k == 0)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .value       (value),
         .in_list     (in_list),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .hit_in      (hit[k]),
         .entry       (entries[k]),
         .hit_out     (hit[k+1])
      );
   end

   always_comb begin
      unique case (op)
         OP_PUSH_FRONT, OP_INSERT: status_in = full ? ST_FULL : ST_OK;
         OP_POP_FRONT:             status_in = empty ? ST_EMPTY : ST_OK;
         OP_REMOVE:                status_in = hit[DEPTH] ? ST_OK : ST_NOT_FOUND;
         default:                  status_in = ST_OK;
      endcase
   end

   always_comb begin
      cmd.op     = op;
      cmd.commit = accept && (status_in == ST_OK);
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.commit) begin
         unique case (op)
            OP_PUSH_FRONT, OP_INSERT: occ_in = occ_ff + OCC_BITS'(1);
            OP_POP_FRONT, OP_REMOVE:  occ_in = occ_ff - OCC_BITS'(1);
            default:                  occ_in = occ_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // The list only changes when a new beat is taken, which also replaces the
   // result, so count and head are read straight from the current state.
   assign count_out = COUNT_BITS'(occ_ff);
   assign head_out  = empty ? '0 : entries[0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, head_out, count_out};

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the sorted list engine with a built-in list predictor.
module tb;
   import sle_pkg::*;

   localparam int DEPTH       = 16;
   localparam int VALUE_BITS  = 32;
   localparam int REQ_W       = 32;
   localparam int RSP_W       = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int ROUNDS      = 2;
   localparam int PHASE_ITEMS = 220;
   localparam int N_DIRECTED  = 25;

   typedef struct packed {
      status_type             status;
      logic [COUNT_BITS-1:0]  count;
      logic signed [31:0]     head;
   } list_result_type;

   typedef struct packed {
      op_type                 op;
      logic signed [31:0]     value;
      logic                   known;
      status_type             status;
      logic [COUNT_BITS-1:0]  count;
      logic signed [31:0]     head;
   } stim_row_type;

   localparam logic signed [31:0] VMIN = 32'sh8000_0000;
   localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{OP_POP_FRONT,  32'sd0,     1'b1, ST_EMPTY,     5'd0,  32'sd0},
      '{OP_REMOVE,     32'sd5,     1'b1, ST_NOT_FOUND, 5'd0,  32'sd0},
      '{OP_PUSH_FRONT, VMAX,       1'b1, ST_OK,        5'd1,  VMAX},
      '{OP_INSERT,     VMIN,       1'b1, ST_OK,        5'd2,  VMIN},
      '{OP_INSERT,     VMIN,       1'b1, ST_OK,        5'd3,  VMIN},
      '{OP_INSERT,     32'sd0,     1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_INSERT,     -32'sd1,    1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_REMOVE,     VMAX,       1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_REMOVE,     32'sd12345, 1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd100,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd101,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd102,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd103,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd104,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd105,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd106,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd107,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd108,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd109,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd110,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd111,   1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_PUSH_FRONT, 32'sd999,   1'b1, ST_FULL,      5'd16, 32'sd111},
      '{OP_INSERT,     -32'sd7,    1'b1, ST_FULL,      5'd16, 32'sd111},
      '{OP_POP_FRONT,  32'sd0,     1'b0, ST_OK,        5'd0,  32'sd0},
      '{OP_REMOVE,     32'sd0,     1'b0, ST_OK,        5'd0,  32'sd0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic [1:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic [1:0]        rsp_tuser;

   logic              fixed_known = 1'b0;
   list_result_type   fixed_result = '0;
   int                stall_pct = 0;
   logic              hold_toggle = 1'b0;
   logic              hold_seen = 1'b0;
   int                hold_left = 0;

   logic signed [31:0] list_q [DEPTH];
   int                 fill = 0;
   list_result_type    pending_results [$];
   int                 error_count = 0;

   sorted_list_engine #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   function automatic void put_entry(int pos, logic signed [31:0] v);
      for (int k = fill; k > pos; k--) begin
         list_q[k] = list_q[k-1];
      end
      list_q[pos] = v;
      fill++;
   endfunction

   function automatic void drop_entry(int pos);
      for (int k = pos; k + 1 < fill; k++) begin
         list_q[k] = list_q[k+1];
      end
      fill--;
   endfunction

   function automatic list_result_type apply_list_op(op_type op, logic signed [31:0] v);
      list_result_type r;
      int pos;
      r.status = ST_OK;
      case (op)
         OP_PUSH_FRONT: begin
            if (fill >= DEPTH) r.status = ST_FULL;
            else put_entry(0, v);
         end
         OP_INSERT: begin
            if (fill >= DEPTH) begin
               r.status = ST_FULL;
            end else if (fill == 0 || v < list_q[0]) begin
               put_entry(0, v);
            end else begin
               pos = 1;
               while (pos < fill && list_q[pos] < v) pos++;
               put_entry(pos, v);
            end
         end
         OP_POP_FRONT: begin
            if (fill == 0) r.status = ST_EMPTY;
            else drop_entry(0);
         end
         default: begin
            pos = 0;
            while (pos < fill && list_q[pos] != v) pos++;
            if (pos < fill) drop_entry(pos);
            else r.status = ST_NOT_FOUND;
         end
      endcase
      r.count = COUNT_BITS'(fill);
      r.head  = (fill > 0) ? list_q[0] : 32'sd0;
      return r;
   endfunction

   // Results are checked before new requests are predicted, since a result never
   // leaves in the cycle its request beat is taken.
   always @(posedge clock) begin : beat_monitor
      list_result_type want;
      list_result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.count  = rsp_tdata[COUNT_BITS-1:0];
            got.head   = rsp_tdata[COUNT_BITS +: 32];
            if (pending_results.size() == 0) begin
               $error("result beat arrived with no pending expectation");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d", want.count, got.count);
                  error_count++;
               end
               if (got.head !== want.head) begin
                  $error("head_value: expected %0d, got %0d", want.head, got.head);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_list_op(op_type'(req_tuser), $signed(req_tdata));
            if (fixed_known) want = fixed_result;
            pending_results.push_back(want);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_seen != hold_toggle) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_beat(op_type op, logic signed [31:0] v, logic known,
                            list_result_type fixed, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= v;
      req_tuser    <= op;
      fixed_known  <= known;
      fixed_result <= fixed;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 40) return $signed(32'($urandom_range(16))) - 32'sd8;
      if (r < 50) begin
         case ($urandom_range(4))
            0: return VMIN;
            1: return VMAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
         endcase
      end
      return $signed($urandom);
   endfunction

   // Fill-leaning and drain-leaning stretches alternate so that the list swings
   // between empty and full; removals mostly target values that are present.
   task automatic send_random(bit grow, int idle_pct);
      int r;
      op_type op;
      logic signed [31:0] v;
      r = $urandom_range(99);
      if (grow) op = (r < 35) ? OP_PUSH_FRONT : (r < 75) ? OP_INSERT :
                     (r < 85) ? OP_POP_FRONT : OP_REMOVE;
      else      op = (r < 10) ? OP_PUSH_FRONT : (r < 25) ? OP_INSERT :
                     (r < 65) ? OP_POP_FRONT : OP_REMOVE;
      v = pick_value();
      if (op == OP_REMOVE && fill > 0 && $urandom_range(99) < 70)
         v = list_q[$urandom_range(fill - 1)];
      send_beat(op, v, 1'b0, '0, idle_pct);
   endtask

   initial begin
      int send_idle;
      list_result_type fixed;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         fixed.status = DIRECTED[i].status;
         fixed.count  = DIRECTED[i].count;
         fixed.head   = DIRECTED[i].head;
         send_beat(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].known, fixed, 0);
      end
      wait_drained();

      for (int round = 0; round < ROUNDS; round++) begin
         for (int phase = 0; phase < 4; phase++) begin
            case (phase)
               0: begin send_idle = 0;  stall_pct <= 0;  end
               1: begin send_idle = 76; stall_pct <= 0;  end
               2: begin send_idle = 0;  stall_pct <= 76; end
               default: begin send_idle = 14; stall_pct <= 14; end
            endcase
            if (round == 0 && phase == 0) begin
               hold_toggle <= ~hold_toggle;
               for (int n = 0; n < 20; n++) send_random(1'b1, 0);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
               send_random(((n / 40) % 2) == 0, send_idle);
            end
            wait_drained();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_list_engine test passed");
      end else begin
         $display("sorted_list_engine test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("sorted_list_engine test failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sle_pkg.sv
rtl/core/sle_cell.sv
rtl/core/sorted_list_engine.sv
tb/sv/tb.sv
